@@ hdl/bspw_pkg.sv @@
package bspw_pkg;

    // fixed field widths
    localparam int IDX_W       = 12;
    localparam int COORD_W     = 32;
    localparam int NORM_W      = 18;
    localparam int KIND_W      = 3;
    localparam int CHILD_W     = 13;
    localparam int CONT_W      = 32;
    localparam int REQ_W       = 2;
    localparam int AXIAL_KINDS = 3;

    // dot product: 32x18 products, three of them less dist<<16
    localparam int DIST_SHIFT  = 16;
    localparam int PROD_W      = COORD_W + NORM_W;
    localparam int ACC_W       = PROD_W + 3;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PLANE = 2'd0,
        REQ_NODE  = 2'd1,
        REQ_LEAF  = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic signed [COORD_W-1:0] distance;
    } t_plane;

    typedef struct packed {
        logic [IDX_W-1:0]          plane_ref;
        logic signed [CHILD_W-1:0] front;
        logic signed [CHILD_W-1:0] back;
    } t_node;

    // table write strobes from the request decode
    typedef struct packed {
        logic             plane_we;
        logic             node_we;
        logic             leaf_we;
        logic [IDX_W-1:0] addr;
    } t_tbl_wr;

    // table read strobes from the walk sequencer
    typedef struct packed {
        logic             node_re;
        logic [IDX_W-1:0] node_addr;
        logic             plane_re;
        logic [IDX_W-1:0] plane_addr;
        logic             leaf_re;
        logic [IDX_W-1:0] leaf_addr;
    } t_tbl_rd;

    // clamp a 32-bit value to the signed Q1.16 normal range
    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [COORD_W-1:0] v);
        logic fits;
        fits = (v[COORD_W-1:NORM_W-1] == {(COORD_W-NORM_W+1){v[COORD_W-1]}});
        if (fits) begin
            sat_norm = v[NORM_W-1:0];
        end else if (v[COORD_W-1]) begin
            sat_norm = {1'b1, {(NORM_W-1){1'b0}}};
        end else begin
            sat_norm = {1'b0, {(NORM_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ hdl/bspw_tables.sv @@
module bspw_tables #(
    parameter int PLANE_COUNT = 4096,
    parameter int NODE_COUNT  = 4096,
    parameter int LEAF_COUNT  = 4096
) (
    input  logic                               i_clk,
    input  bspw_pkg::t_tbl_wr                  i_wr,
    input  bspw_pkg::t_plane                   i_plane_wdata,
    input  bspw_pkg::t_node                    i_node_wdata,
    input  logic [bspw_pkg::CONT_W-1:0]        i_leaf_wdata,
    input  bspw_pkg::t_tbl_rd                  i_rd,
    output bspw_pkg::t_plane                   o_plane,
    output bspw_pkg::t_node                    o_node,
    output logic [bspw_pkg::CONT_W-1:0]        o_leaf
);
    import bspw_pkg::*;

    // entries past the 12-bit index space can never be reached
    localparam int IDX_SPAN    = 2 ** IDX_W;
    localparam int PLANE_DEPTH = (PLANE_COUNT < IDX_SPAN) ? PLANE_COUNT : IDX_SPAN;
    localparam int NODE_DEPTH  = (NODE_COUNT < IDX_SPAN) ? NODE_COUNT : IDX_SPAN;
    localparam int LEAF_DEPTH  = (LEAF_COUNT < IDX_SPAN) ? LEAF_COUNT : IDX_SPAN;
    localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int LEAF_AW     = $clog2(LEAF_DEPTH);

    t_plane              r_plane_mem [PLANE_DEPTH];
    t_node               r_node_mem  [NODE_DEPTH];
    logic [CONT_W-1:0]   r_leaf_mem  [LEAF_DEPTH];

    t_plane              r_plane_q;
    t_node               r_node_q;
    logic [CONT_W-1:0]   r_leaf_q;

    logic                plane_in_range;
    logic                node_in_range;
    logic                leaf_in_range;

    // writes past the table end are dropped
    assign plane_in_range = (32'(i_wr.addr) < PLANE_COUNT);
    assign node_in_range  = (32'(i_wr.addr) < NODE_COUNT);
    assign leaf_in_range  = (32'(i_wr.addr) < LEAF_COUNT);

    // plane table
    always_ff @(posedge i_clk) begin
        if (i_wr.plane_we && plane_in_range) begin
            r_plane_mem[i_wr.addr[PLANE_AW-1:0]] <= i_plane_wdata;
        end
        if (i_rd.plane_re) begin
            r_plane_q <= r_plane_mem[i_rd.plane_addr[PLANE_AW-1:0]];
        end
    end

    // node table
    always_ff @(posedge i_clk) begin
        if (i_wr.node_we && node_in_range) begin
            r_node_mem[i_wr.addr[NODE_AW-1:0]] <= i_node_wdata;
        end
        if (i_rd.node_re) begin
            r_node_q <= r_node_mem[i_rd.node_addr[NODE_AW-1:0]];
        end
    end

    // leaf contents table
    always_ff @(posedge i_clk) begin
        if (i_wr.leaf_we && leaf_in_range) begin
            r_leaf_mem[i_wr.addr[LEAF_AW-1:0]] <= i_leaf_wdata;
        end
        if (i_rd.leaf_re) begin
            r_leaf_q <= r_leaf_mem[i_rd.leaf_addr[LEAF_AW-1:0]];
        end
    end

    assign o_plane = r_plane_q;
    assign o_node  = r_node_q;
    assign o_leaf  = r_leaf_q;

endmodule

@@ hdl/bsp_point_leaf_walk.sv @@
// Channel   | Direction | Handshake                         | Payload
// ----------+-----------+-----------------------------------+------------------------------------
// request   | in        | start, busy (taken: start & !busy)| i_req_type .. i_head_node
// result    | out       | o_done (one-cycle strobe)         | o_found_leaf, o_point_contents,
//           |           |                                   | o_walk_overflow
// config    | in/out    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// Table writes leave busy low and no result follows.
// A query with the map unloaded answers in the cycle after it is taken.
// A loaded query walks one node at a time: an axial node takes a node read, a plane read
// and an evaluation; a general node adds three passes through the one 32x18 multiplier
// and a final add; a leaf takes the leaf read, and o_done is registered from that state.
// Synchronous active-low reset clears the sequencer, the map flag and the strobe;
// the tables are not cleared. The receiver cannot stall; busy holds off new requests.
module bsp_point_leaf_walk #(
    parameter int PLANE_COUNT    = 4096,
    parameter int NODE_COUNT     = 4096,
    parameter int LEAF_COUNT     = 4096,
    parameter int MAX_WALK_STEPS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [bspw_pkg::REQ_W-1:0]            i_req_type,
    input  logic [bspw_pkg::IDX_W-1:0]            i_entry_index,
    input  logic [bspw_pkg::IDX_W-1:0]            i_plane_ref,
    input  logic [bspw_pkg::KIND_W-1:0]           i_plane_kind,
    input  logic signed [bspw_pkg::COORD_W-1:0]   i_vec_x,
    input  logic signed [bspw_pkg::COORD_W-1:0]   i_vec_y,
    input  logic signed [bspw_pkg::COORD_W-1:0]   i_vec_z,
    input  logic signed [bspw_pkg::COORD_W-1:0]   i_plane_dist,
    input  logic signed [bspw_pkg::CHILD_W-1:0]   i_child_front,
    input  logic signed [bspw_pkg::CHILD_W-1:0]   i_child_back,
    input  logic [bspw_pkg::CONT_W-1:0]           i_leaf_contents,
    input  logic signed [bspw_pkg::CHILD_W-1:0]   i_head_node,
    output logic                                  o_done,
    output logic [bspw_pkg::IDX_W-1:0]            o_found_leaf,
    output logic [bspw_pkg::CONT_W-1:0]           o_point_contents,
    output logic                                  o_walk_overflow,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import bspw_pkg::*;

    localparam int STEP_W = $clog2(MAX_WALK_STEPS + 1);
    localparam logic REG_MAP_LOADED = 1'b0;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_NODE  = 7'b0000010,
        ST_PLANE = 7'b0000100,
        ST_EVAL  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ACC   = 7'b0100000,
        ST_LEAF  = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic signed [CHILD_W-1:0]   r_node, n_node;
    logic signed [COORD_W-1:0]   r_px, n_px;
    logic signed [COORD_W-1:0]   r_py, n_py;
    logic signed [COORD_W-1:0]   r_pz, n_pz;
    logic [STEP_W-1:0]           r_steps, n_steps;
    logic [1:0]                  r_k, n_k;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic signed [ACC_W-1:0]     r_acc, n_acc;
    logic                        r_plane_bad, n_plane_bad;
    logic [IDX_W-1:0]            r_leaf, n_leaf;
    logic                        r_leaf_ok, n_leaf_ok;
    logic                        r_map_loaded;
    logic                        r_done, n_done;
    logic [IDX_W-1:0]            r_found_leaf, n_found_leaf;
    logic [CONT_W-1:0]           r_contents, n_contents;
    logic                        r_ovf, n_ovf;

    logic                        accept;
    logic                        cfg_wr;
    t_tbl_wr                     tbl_wr;
    t_tbl_rd                     tbl_rd;
    t_plane                      plane_wdata;
    t_node                       node_wdata;
    t_plane                      plane_q;
    t_node                       node_q;
    logic [CONT_W-1:0]           leaf_q;

    logic [IDX_W-1:0]            leaf_idx_c;
    logic                        leaf_ok_c;
    logic                        node_ok_c;
    logic                        plane_ok_c;
    logic [KIND_W-1:0]           kind_eff;
    logic signed [COORD_W-1:0]   dist_eff;
    logic signed [COORD_W-1:0]   p_axial;
    logic signed [COORD_W:0]     d_axial;
    logic signed [ACC_W-1:0]     dist_term;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [COORD_W-1:0]   mul_a;
    logic signed [NORM_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]    mul_p;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAP_LOADED) ? {31'b0, r_map_loaded} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_loaded <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_MAP_LOADED) begin
            r_map_loaded <= pwdata[0];
        end
    end

    // table write decode
    always_comb begin
        tbl_wr.plane_we = accept && (i_req_type == REQ_PLANE);
        tbl_wr.node_we  = accept && (i_req_type == REQ_NODE);
        tbl_wr.leaf_we  = accept && (i_req_type == REQ_LEAF);
        tbl_wr.addr     = i_entry_index;
        plane_wdata.kind     = i_plane_kind;
        plane_wdata.nx       = sat_norm(i_vec_x);
        plane_wdata.ny       = sat_norm(i_vec_y);
        plane_wdata.nz       = sat_norm(i_vec_z);
        plane_wdata.distance = i_plane_dist;
        node_wdata.plane_ref = i_plane_ref;
        node_wdata.front     = i_child_front;
        node_wdata.back      = i_child_back;
    end

    bspw_tables #(
        .PLANE_COUNT (PLANE_COUNT),
        .NODE_COUNT  (NODE_COUNT),
        .LEAF_COUNT  (LEAF_COUNT)
    ) u_tables (
        .i_clk         (i_clk),
        .i_wr          (tbl_wr),
        .i_plane_wdata (plane_wdata),
        .i_node_wdata  (node_wdata),
        .i_leaf_wdata  (i_leaf_contents),
        .i_rd          (tbl_rd),
        .o_plane       (plane_q),
        .o_node        (node_q),
        .o_leaf        (leaf_q)
    );

    // node and leaf range checks; a negative node c names leaf ~c
    assign leaf_idx_c = ~r_node[IDX_W-1:0];
    assign leaf_ok_c  = (32'(leaf_idx_c) < LEAF_COUNT);
    assign node_ok_c  = !r_node[CHILD_W-1] && (32'(r_node[IDX_W-1:0]) < NODE_COUNT)
                        && (r_steps < STEP_W'(MAX_WALK_STEPS));
    assign plane_ok_c = (32'(node_q.plane_ref) < PLANE_COUNT);

    // table read strobes
    always_comb begin
        tbl_rd.node_re    = (r_state == ST_NODE) && node_ok_c;
        tbl_rd.node_addr  = r_node[IDX_W-1:0];
        tbl_rd.plane_re   = (r_state == ST_PLANE) && plane_ok_c;
        tbl_rd.plane_addr = node_q.plane_ref;
        tbl_rd.leaf_re    = (r_state == ST_NODE) && r_node[CHILD_W-1] && leaf_ok_c;
        tbl_rd.leaf_addr  = leaf_idx_c;
    end

    // axial distance: one coordinate less the plane distance
    assign kind_eff = r_plane_bad ? '0 : plane_q.kind;
    assign dist_eff = r_plane_bad ? '0 : plane_q.distance;
    always_comb begin
        case (kind_eff)
            3'd0:    p_axial = r_px;
            3'd1:    p_axial = r_py;
            default: p_axial = r_pz;
        endcase
    end
    assign d_axial   = {p_axial[COORD_W-1], p_axial} - {dist_eff[COORD_W-1], dist_eff};
    assign dist_term = {{(ACC_W-COORD_W-DIST_SHIFT){dist_eff[COORD_W-1]}}, dist_eff,
                        {DIST_SHIFT{1'b0}}};

    // shared multiplier: one coordinate times one normal part per cycle
    always_comb begin
        case (r_k)
            2'd0: begin
                mul_a = r_px;
                mul_b = plane_q.nx;
            end
            2'd1: begin
                mul_a = r_py;
                mul_b = plane_q.ny;
            end
            default: begin
                mul_a = r_pz;
                mul_b = plane_q.nz;
            end
        endcase
    end
    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_sum  = r_acc + prod_ext;

    // walk sequencer
    always_comb begin
        n_state      = r_state;
        n_node       = r_node;
        n_px         = r_px;
        n_py         = r_py;
        n_pz         = r_pz;
        n_steps      = r_steps;
        n_k          = r_k;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_plane_bad  = r_plane_bad;
        n_leaf       = r_leaf;
        n_leaf_ok    = r_leaf_ok;
        n_done       = 1'b0;
        n_found_leaf = r_found_leaf;
        n_contents   = r_contents;
        n_ovf        = r_ovf;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type == REQ_QUERY) begin
                    if (r_map_loaded) begin
                        n_px    = i_vec_x;
                        n_py    = i_vec_y;
                        n_pz    = i_vec_z;
                        n_node  = i_head_node;
                        n_steps = '0;
                        n_state = ST_NODE;
                    end else begin
                        n_done       = 1'b1;
                        n_found_leaf = '0;
                        n_contents   = '0;
                        n_ovf        = 1'b0;
                    end
                end
            end
            ST_NODE: begin
                if (r_node[CHILD_W-1]) begin
                    n_leaf    = leaf_idx_c;
                    n_leaf_ok = leaf_ok_c;
                    n_state   = ST_LEAF;
                end else if (!node_ok_c) begin
                    // step bound hit or node past the table
                    n_done       = 1'b1;
                    n_found_leaf = '0;
                    n_contents   = '0;
                    n_ovf        = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_PLANE;
                end
            end
            ST_PLANE: begin
                n_plane_bad = !plane_ok_c;
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                if (kind_eff < KIND_W'(AXIAL_KINDS)) begin
                    n_node  = d_axial[COORD_W] ? node_q.back : node_q.front;
                    n_steps = r_steps + 1'b1;
                    n_state = ST_NODE;
                end else begin
                    n_acc   = -dist_term;
                    n_k     = 2'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod = mul_p;
                if (r_k != 2'd0) begin
                    n_acc = acc_sum;
                end
                n_k = r_k + 1'b1;
                if (r_k == 2'd2) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_node  = acc_sum[ACC_W-1] ? node_q.back : node_q.front;
                n_steps = r_steps + 1'b1;
                n_state = ST_NODE;
            end
            ST_LEAF: begin
                n_done       = 1'b1;
                n_found_leaf = r_leaf;
                n_contents   = r_leaf_ok ? leaf_q : '0;
                n_ovf        = 1'b0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_steps <= '0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
            r_k     <= n_k;
            r_done  <= n_done;
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_px         <= n_px;
        r_py         <= n_py;
        r_pz         <= n_pz;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_plane_bad  <= n_plane_bad;
        r_leaf       <= n_leaf;
        r_leaf_ok    <= n_leaf_ok;
        r_found_leaf <= n_found_leaf;
        r_contents   <= n_contents;
        r_ovf        <= n_ovf;
    end

    assign o_done           = r_done;
    assign o_found_leaf     = r_found_leaf;
    assign o_point_contents = r_contents;
    assign o_walk_overflow  = r_ovf;

    // result strobe only while idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while walk still busy");

    // unloaded map answers zero on the next cycle
    a_unloaded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_QUERY && !r_map_loaded) |=>
        (o_done && !o_walk_overflow && o_found_leaf == '0 && o_point_contents == '0))
        else $error("unloaded query did not answer zero");

    // table writes produce no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type != REQ_QUERY) |=> (!o_done && !busy))
        else $error("write request produced a result or held busy");

    // overflow result carries zero leaf and contents
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_walk_overflow) |-> (o_found_leaf == '0 && o_point_contents == '0))
        else $error("overflow result with nonzero payload");

    // step count never passes the bound
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(MAX_WALK_STEPS))
        else $error("walk step count past bound");

endmodule
